// ===== rtl/core/pfde_pkg.sv =====
package pfde_pkg;

  localparam int unsigned Columns   = 132;
  localparam int unsigned Pages     = 8;
  localparam int unsigned Rows      = Pages * 8;
  localparam int unsigned StoreSize = Columns * Pages;
  localparam int unsigned AddrW     = $clog2(StoreSize);
  localparam int unsigned PageW     = (Pages > 1) ? $clog2(Pages) : 1;

  typedef enum logic [2:0] {
    ModeSet     = 3'd0,
    ModeClear   = 3'd1,
    ModeOutline = 3'd2,
    ModeFill    = 3'd3,
    ModeScreen  = 3'd4,
    ModeRead    = 3'd5
  } mode_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] first_x;
    logic [7:0] first_y;
    logic [7:0] second_x;
    logic [7:0] second_y;
    logic [7:0] fill_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } rsp_t;

endpackage

// ===== rtl/core/page_framebuffer_draw_engine.sv =====
// A valid pixel or read item passes through the read and modify states before its result is valid.
// A rectangle reads each touched byte, then modifies and writes it;
// fill screen writes every byte of the memory in turn, 1056 bytes at the default size.
// One item is worked at a time; the next is taken in the cycle after the result is accepted.
// After reset a clearing pass writes zero to every byte while in_ready_o stays low.
module page_framebuffer_draw_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pfde_pkg::cmd_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pfde_pkg::rsp_t  out_data_o
);
  import pfde_pkg::*;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StRead  = 6'b000100,
    StMod   = 6'b001000,
    StFill  = 6'b010000,
    StResp  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Frame memory, one write or one read per cycle, registered read data.
  logic [7:0]       mem [StoreSize];
  logic [7:0]       rdata_q;
  logic             we, re;
  logic [AddrW-1:0] addr;
  logic [7:0]       wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[addr];
    end
  end

  // Item registers. The byte walk covers column xlo..xhi for each page plo..phi.
  logic [2:0]       mode_q;
  logic [7:0]       xlo_q, xhi_q, ylo_q, yhi_q, x_q, fill_q;
  logic [PageW-1:0] pg_q, phi_q;
  logic [AddrW-1:0] addr_q;
  logic             status_q;
  logic [7:0]       rbyte_q;

  // Command decode.
  logic [7:0] ax, bx, cxl, cxh, cyl, cyh;
  logic       pix_bad, rect_bad;
  always_comb begin
    ax = (in_data_i.first_x >= 8'(Columns - 1)) ? 8'(Columns - 1) : in_data_i.first_x;
    bx = (in_data_i.second_x >= 8'(Columns - 1)) ? 8'(Columns - 1) : in_data_i.second_x;
    cxl = (ax < bx) ? ax : bx;
    cxh = (ax < bx) ? bx : ax;
    cyl = (in_data_i.first_y < in_data_i.second_y) ? in_data_i.first_y : in_data_i.second_y;
    cyh = (in_data_i.first_y < in_data_i.second_y) ? in_data_i.second_y : in_data_i.first_y;
    pix_bad  = (9'(in_data_i.first_x) >= 9'(Columns)) || (9'(in_data_i.first_y) >= 9'(Rows));
    rect_bad = (9'(in_data_i.first_y) >= 9'(Rows)) || (9'(in_data_i.second_y) >= 9'(Rows));
  end

  // Bit mask of the current byte: which rows of the page get set or cleared.
  logic [7:0] mask;
  logic [8:0] row0;
  logic       col_edge;
  always_comb begin
    mask     = '0;
    col_edge = (x_q == xlo_q) || (x_q == xhi_q);
    for (int b = 0; b < 8; b++) begin
      row0 = {1'b0, 5'(pg_q), 3'(b)};
      if (row0 >= {1'b0, ylo_q} && row0 <= {1'b0, yhi_q}) begin
        if (mode_q == ModeFill || col_edge) begin
          mask[b] = 1'b1;
        end else if (row0 == {1'b0, ylo_q} || row0 == {1'b0, yhi_q}) begin
          mask[b] = 1'b1;
        end
      end
    end
  end

  logic last_byte;
  assign last_byte = (x_q == xhi_q) && (pg_q == phi_q);

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    re = 1'b0;
    addr = addr_q;
    wdata = 8'h00;
    unique case (state_q)
      StClear: begin
        we = 1'b1;
        if (addr_q == AddrW'(StoreSize - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) state_d = StResp;
        if (in_valid_i && !(
            (in_data_i.mode == ModeScreen) ||
            ((in_data_i.mode == ModeSet || in_data_i.mode == ModeClear ||
              in_data_i.mode == ModeRead) && !pix_bad) ||
            ((in_data_i.mode == ModeOutline || in_data_i.mode == ModeFill) && !rect_bad)))
          state_d = StResp;
        else if (in_valid_i && in_data_i.mode == ModeScreen) state_d = StFill;
        else if (in_valid_i) state_d = StRead;
      end
      StRead: begin
        re = 1'b1;
        state_d = StMod;
      end
      StMod: begin
        if (mode_q != ModeRead) begin
          we = 1'b1;
          wdata = (mode_q == ModeClear) ? (rdata_q & ~mask) : (rdata_q | mask);
        end
        state_d = (mode_q == ModeRead || last_byte) ? StResp : StRead;
      end
      StFill: begin
        we = 1'b1;
        wdata = fill_q;
        if (addr_q == AddrW'(StoreSize - 1)) state_d = StResp;
      end
      StResp: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  logic [PageW-1:0] npg;
  logic [7:0]       nx;
  always_comb begin
    nx  = (x_q == xhi_q) ? xlo_q : x_q + 8'd1;
    npg = (x_q == xhi_q) ? pg_q + PageW'(1) : pg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear || state_q == StFill) begin
        addr_q <= (addr_q == AddrW'(StoreSize - 1)) ? '0 : addr_q + AddrW'(1);
      end else if (state_q == StIdle && in_valid_i) begin
        // Fill screen walks the whole memory from the first byte.
        if (in_data_i.mode == ModeScreen) begin
          addr_q <= '0;
        end else if (in_data_i.mode == ModeOutline || in_data_i.mode == ModeFill) begin
          addr_q <= AddrW'(32'(cyl[7:3]) * Columns + 32'(cxl));
        end else begin
          addr_q <= AddrW'(32'(in_data_i.first_y[7:3]) * Columns + 32'(in_data_i.first_x));
        end
      end else if (state_q == StMod && !last_byte) begin
        addr_q <= AddrW'(32'(npg) * Columns + 32'(nx));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      mode_q   <= in_data_i.mode;
      fill_q   <= in_data_i.fill_value;
      rbyte_q  <= 8'h00;
      status_q <= 1'b0;
      if (in_data_i.mode == ModeOutline || in_data_i.mode == ModeFill) begin
        xlo_q <= cxl; xhi_q <= cxh; ylo_q <= cyl; yhi_q <= cyh;
        x_q <= cxl; pg_q <= PageW'(cyl[7:3]); phi_q <= PageW'(cyh[7:3]);
        status_q <= rect_bad;
      end else begin
        xlo_q <= in_data_i.first_x; xhi_q <= in_data_i.first_x;
        ylo_q <= in_data_i.first_y; yhi_q <= in_data_i.first_y;
        x_q <= in_data_i.first_x; pg_q <= PageW'(in_data_i.first_y[7:3]);
        phi_q <= PageW'(in_data_i.first_y[7:3]);
        status_q <= (in_data_i.mode == ModeScreen) ? 1'b0 :
                    (in_data_i.mode == ModeSet || in_data_i.mode == ModeClear ||
                     in_data_i.mode == ModeRead) ? pix_bad : 1'b1;
      end
    end else if (state_q == StMod) begin
      if (mode_q == ModeRead) rbyte_q <= rdata_q;
      x_q  <= nx;
      pg_q <= npg;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StResp);
  assign out_data_o  = '{read_byte: rbyte_q, status: status_q};

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle || state_q == StResp) |-> !we) else $error("write while idle");
  a_mod_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMod) |-> $past(state_q == StRead)) else $error("modify without read");
  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o)) else $error("result changed");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pfde_pkg::*;

  // The clock runs at 2 ns. Reset starts low and is then released.
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  cmd_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  page_framebuffer_draw_engine u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // This is the testbench's own copy of the panel. It is updated once for
  // every item that the block accepts.
  logic [7:0] panel_bytes [StoreSize];
  cmd_t       cmd_queue[$];
  rsp_t       rsp_expected[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_left;
  int  quiet_cycles;
  bit  failed;

  localparam int QuietLimit = 400000;

  // A rectangle over the whole panel is the slowest command, and the stall phases stretch
  // it further. The limit is well above that.

  function automatic void mark_pixel(int x, int y);
    if (x < Columns && y < Rows) begin
      panel_bytes[(y / 8) * Columns + x][y % 8] = 1'b1;
    end
  endfunction

  // Apply one command to the panel copy and return the response it should give.
  function automatic rsp_t draw_and_answer(cmd_t c);
    rsp_t r;
    int   ax, ay, bx, by, xlo, xhi, ylo, yhi;
    r = '0;
    ax = c.first_x;
    ay = c.first_y;
    bx = c.second_x;
    by = c.second_y;
    case (c.mode)
      ModeSet, ModeClear, ModeRead: begin
        if (ax >= Columns || ay >= Rows) begin
          r.status = 1'b1;
        end else if (c.mode == ModeRead) begin
          r.read_byte = panel_bytes[(ay / 8) * Columns + ax];
        end else begin
          panel_bytes[(ay / 8) * Columns + ax][ay % 8] = (c.mode == ModeSet);
        end
      end
      ModeOutline, ModeFill: begin
        if (ay >= Rows || by >= Rows) begin
          r.status = 1'b1;
        end else begin
          // A corner past the right edge is pulled back to the last column.
          if (ax >= Columns) ax = Columns - 1;
          if (bx >= Columns) bx = Columns - 1;
          xlo = (ax < bx) ? ax : bx;
          xhi = (ax < bx) ? bx : ax;
          ylo = (ay < by) ? ay : by;
          yhi = (ay < by) ? by : ay;
          for (int y = ylo; y <= yhi; y++) begin
            for (int x = xlo; x <= xhi; x++) begin
              if (c.mode == ModeFill || x == xlo || x == xhi || y == ylo || y == yhi) begin
                mark_pixel(x, y);
              end
            end
          end
        end
      end
      ModeScreen: begin
        foreach (panel_bytes[i]) panel_bytes[i] = c.fill_value;
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // The driver. It offers a new item at random, following the sender's idle
  // rate, and keeps each offer steady until the block takes it.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_expected.push_back(draw_and_answer(in_data));
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cmd_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The monitor. It checks each response against the oldest expected one and
  // drives the receiver's stalls, including the long hold-off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: response with nothing expected: got %h", $realtime, out_data);
          failed = 1'b1;
        end else begin
          if (out_data.read_byte !== rsp_expected[0].read_byte) begin
            $display("%0t: read_byte mismatch: expected %h, got %h", $realtime,
                     rsp_expected[0].read_byte, out_data.read_byte);
            failed = 1'b1;
          end
          if (out_data.status !== rsp_expected[0].status) begin
            $display("%0t: status mismatch: expected %h, got %h", $realtime,
                     rsp_expected[0].status, out_data.status);
            failed = 1'b1;
          end
          void'(rsp_expected.pop_front());
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // The watchdog counts cycles in which neither handshake completes.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Random coordinates lean toward the panel, with some values off its edges.
  function automatic logic [7:0] pick_coord(int span);
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'($urandom_range(255));
    if (pick == 1) return 8'(span - 1 + $urandom_range(1));
    return 8'($urandom_range(span - 1));
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   size;
    c = '0;
    c.second_x   = 8'($urandom_range(255));
    c.second_y   = 8'($urandom_range(255));
    c.fill_value = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 25)      c.mode = ModeSet;
    else if (pick < 40) c.mode = ModeClear;
    else if (pick < 70) c.mode = ModeRead;
    else if (pick < 85) c.mode = ModeOutline;
    else if (pick < 97) c.mode = ModeFill;
    else if (pick < 98) c.mode = ModeScreen;
    else                c.mode = 3'($urandom_range(6, 7));
    c.first_x = pick_coord(Columns);
    c.first_y = pick_coord(Rows);
    if (c.mode == ModeOutline || c.mode == ModeFill) begin
      // Rectangles are mostly small so the run stays short.
      size = ($urandom_range(19) == 0) ? 255 : 12;
      c.second_x = 8'(c.first_x + $urandom_range(size) - size / 2);
      c.second_y = 8'(c.first_y + $urandom_range(size) - size / 2);
      if ($urandom_range(9) == 0) c.second_y = 8'($urandom_range(255));
    end
    return c;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] m, int ax, int ay, int bx, int by, int fv);
    cmd_t c;
    c.mode       = m;
    c.first_x    = 8'(ax);
    c.first_y    = 8'(ay);
    c.second_x   = 8'(bx);
    c.second_y   = 8'(by);
    c.fill_value = 8'(fv);
    return c;
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid || rsp_expected.size() > 0) @(posedge clk);
  endtask

  initial begin
    failed         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    quiet_cycles   = 0;
    rst_n          = 1'b0;
    // The block clears its panel after reset, so the copy starts blank too.
    foreach (panel_bytes[i]) panel_bytes[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: the panel corners, each command, and every way a
    // command can be ignored or clipped.
    cmd_queue.push_back(make_cmd(ModeRead, 0, 0, 255, 255, 255));
    cmd_queue.push_back(make_cmd(ModeSet, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeSet, Columns - 1, Rows - 1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeRead, Columns - 1, Rows - 1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeSet, Columns, 3, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeSet, 5, Rows, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeRead, 255, 255, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeClear, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeClear, 255, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeRead, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeOutline, 20, 30, 10, 2, 0));
    cmd_queue.push_back(make_cmd(ModeRead, 15, 2, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeFill, 200, 9, 125, 9, 0));
    cmd_queue.push_back(make_cmd(ModeRead, Columns - 1, 9, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeOutline, 7, 7, 7, 7, 0));
    cmd_queue.push_back(make_cmd(ModeFill, 1, Rows, 2, 3, 0));
    cmd_queue.push_back(make_cmd(ModeOutline, 1, 3, 2, 255, 0));
    cmd_queue.push_back(make_cmd(3'd6, 1, 1, 1, 1, 1));
    cmd_queue.push_back(make_cmd(3'd7, 255, 255, 255, 255, 255));
    cmd_queue.push_back(make_cmd(ModeScreen, 255, 255, 255, 255, 8'hff));
    cmd_queue.push_back(make_cmd(ModeClear, 40, 20, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeRead, 40, 20, 0, 0, 0));
    cmd_queue.push_back(make_cmd(ModeScreen, 0, 0, 0, 0, 8'h00));
    cmd_queue.push_back(make_cmd(ModeFill, 0, 0, 255, Rows - 1, 0));
    cmd_queue.push_back(make_cmd(ModeRead, 66, 33, 0, 0, 0));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering items, so the
    // block fills up and stalls its input.
    for (int i = 0; i < 20; i++) cmd_queue.push_back(random_cmd());
    hold_off_left = 300;
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both, then no idling again.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 300; i++) cmd_queue.push_back(random_cmd());
      // The sender pauses here until every expected response has come.
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (!failed && rsp_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (rsp_expected.size() != 0) begin
        $display("%0t: %0d responses never arrived", $realtime, rsp_expected.size());
      end
      $display("FAILURE");
    end
    $finish;
  end

endmodule
